@@ design/hfbm_pkg.sv @@
// ----------------------------------------------------------------------------
// Hierarchical free bit map package
// Shared widths, operation codes, register indexes and structs.
// ----------------------------------------------------------------------------
package hfbm_pkg;

  localparam int SLOT_W  = 20;
  localparam int CNT_W   = SLOT_W + 1;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 5;
  localparam int WIDX_W  = SLOT_W - POS_W;
  localparam int LEN1_W  = SLOT_W - 2 * POS_W + 1;
  localparam int LEN2_W  = SLOT_W - POS_W + 1;
  localparam int LENT_W  = POS_W + 1;
  localparam int LVL_W   = 2;
  localparam int OP_W    = 3;
  localparam int NUM_LVL = 3;

  localparam int L1_SPAN = WORD_W;
  localparam int L2_SPAN = WORD_W * WORD_W;
  localparam int L3_SPAN = WORD_W * WORD_W * WORD_W;

  localparam int MAX_SLOTS_DEF = 1 << SLOT_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [0:0] REG_SLOT_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(MAX_SLOTS_DEF);

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t ALL_ONES = '1;

  typedef enum logic [OP_W-1:0] {
    OP_INIT_FREE = 3'd0,
    OP_INIT_USED = 3'd1,
    OP_SET       = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_GET       = 3'd4,
    OP_FIND      = 3'd5,
    OP_FIND_SET  = 3'd6
  } op_t;

  typedef struct packed {
    logic [NUM_LVL-1:0]              wr;
    logic [WIDX_W-1:0]               addr;
    logic [NUM_LVL-1:0][WORD_W-1:0]  wdata;
  } mem_cmd_t;

  typedef struct packed {
    word_t            set_word;
    word_t            clr_word;
    logic             bit_val;
    logic             full;
    logic             set_full;
    logic [POS_W-1:0] first_zero;
  } word_info_t;

endpackage

@@ design/hfbm_if.sv @@
// ----------------------------------------------------------------------------
// Hierarchical free bit map channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hfbm_req_if import hfbm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output op, output slot_index, input ready);
  modport sink (input valid, input op, input slot_index, output ready);
endinterface

interface hfbm_rsp_if import hfbm_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] found_index;
  logic              bit_value;

  modport source (output valid, output found, output found_index, output bit_value,
                  input ready);
  modport sink (input valid, input found, input found_index, input bit_value,
                output ready);
endinterface

@@ design/hfbm_ram.sv @@
// ----------------------------------------------------------------------------
// Hierarchical free bit map word RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hfbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/hfbm_word_unit.sv @@
// ----------------------------------------------------------------------------
// Hierarchical free bit map word unit
// Shared per-word logic: bit set and clear, full tests and first-zero search.
// ----------------------------------------------------------------------------
module hfbm_word_unit import hfbm_pkg::*; (
  input  word_t            word,
  input  logic [POS_W-1:0] pos,
  output word_info_t       info
);

  word_t            mask;
  logic [POS_W-1:0] fz;

  always_comb begin
    mask = word_t'(1) << pos;
    fz = POS_W'(WORD_W - 1);
    for (int i = WORD_W - 2; i >= 0; i--) begin
      if (!word[i]) begin
        fz = POS_W'(i);
      end
    end
    info.set_word   = word | mask;
    info.clr_word   = word & ~mask;
    info.bit_val    = word[pos];
    info.full       = (word == ALL_ONES);
    info.set_full   = ((word | mask) == ALL_ONES);
    info.first_zero = fz;
  end

endmodule

@@ design/hfbm_seq.sv @@
// ----------------------------------------------------------------------------
// Hierarchical free bit map sequencer
// Walks the word tree one level at a time and runs the init sweep.
// ----------------------------------------------------------------------------
module hfbm_seq import hfbm_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [CNT_W-1:0]                slot_count,
  hfbm_req_if.sink                        req,
  hfbm_rsp_if.source                      rsp,
  output mem_cmd_t                        mem_cmd,
  input  logic [NUM_LVL-1:0][WORD_W-1:0]  mem_rdata
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INIT_PREP = 7'b0000010,
    S_INIT      = 7'b0000100,
    S_TOP       = 7'b0001000,
    S_RD        = 7'b0010000,
    S_WR        = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic              reset_pass;
  logic              fill_used;

  logic [OP_W-1:0]   cur_op, op_next;
  logic [LVL_W-1:0]  lvl, lvl_next;
  logic [LVL_W-1:0]  lvl_idx;
  logic [SLOT_W-1:0] cur, cur_next;
  logic [SLOT_W-1:0] path, path_next;
  word_t             top_word, top_next;
  logic [LVL_W-1:0]  level_count;
  logic [CNT_W-1:0]  active_count;
  logic [LEN1_W-1:0] len1;
  logic [LEN2_W-1:0] len2;
  logic [CNT_W-1:0]  len3;
  logic [WIDX_W-1:0] sweep_idx;
  logic [WIDX_W-1:0] sweep_last;
  logic              res_found, res_found_next;
  logic [SLOT_W-1:0] res_idx, res_idx_next;
  logic              res_bit, res_bit_next;

  logic              in_range;
  logic              find_mode;
  logic              find_done;
  logic [SLOT_W-1:0] find_idx;
  logic              out_free;

  logic [CNT_W-1:0]  n_raw, n_clamp;
  logic [LEN2_W-1:0] c1;
  logic [LEN1_W-1:0] c2;
  logic [LENT_W-1:0] c3;
  logic [LVL_W-1:0]  lv_n;
  logic [LENT_W-1:0] lt_n;
  logic [LEN1_W-1:0] l1_n;
  logic [LEN2_W-1:0] l2_n;
  logic [CNT_W-1:0]  l3_n;
  word_t             init_top;

  word_t             unit_word;
  word_info_t        wu;

  function automatic logic sweep_hit(input logic [CNT_W-1:0] len,
                                     input logic [WIDX_W-1:0] j);
    logic [CNT_W-1:0] full_words;
    logic [CNT_W-1:0] jj;
    full_words = len >> POS_W;
    jj = CNT_W'(j);
    return (jj < full_words) || ((jj == full_words) && (len[POS_W-1:0] != '0));
  endfunction

  function automatic word_t sweep_word(input logic [CNT_W-1:0] len,
                                       input logic [WIDX_W-1:0] j,
                                       input logic used);
    logic [CNT_W-1:0] full_words;
    full_words = len >> POS_W;
    if (used) begin
      return ALL_ONES;
    end
    if (CNT_W'(j) < full_words) begin
      return '0;
    end
    return ALL_ONES << len[POS_W-1:0];
  endfunction

  assign lvl_idx   = lvl - LVL_W'(1);
  assign in_range  = CNT_W'(req.slot_index) < active_count;
  assign find_mode = (cur_op == OP_FIND) || (cur_op == OP_FIND_SET);
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign unit_word = (state == S_TOP) ? top_word : mem_rdata[lvl_idx];

  hfbm_word_unit u_word_unit (
    .word (unit_word),
    .pos  (cur[POS_W-1:0]),
    .info (wu)
  );

  always_comb begin
    n_raw = reset_pass ? MAX_CNT : slot_count;
    if (n_raw == '0) begin
      n_clamp = CNT_W'(1);
    end else if (n_raw > MAX_CNT) begin
      n_clamp = MAX_CNT;
    end else begin
      n_clamp = n_raw;
    end
    c1 = LEN2_W'((n_clamp + CNT_W'(WORD_W - 1)) >> POS_W);
    c2 = LEN1_W'((c1 + LEN2_W'(WORD_W - 1)) >> POS_W);
    c3 = LENT_W'((c2 + LEN1_W'(WORD_W - 1)) >> POS_W);
    if (n_clamp <= CNT_W'(L1_SPAN)) begin
      lv_n = LVL_W'(0);
    end else if (n_clamp <= CNT_W'(L2_SPAN)) begin
      lv_n = LVL_W'(1);
    end else if (n_clamp <= CNT_W'(L3_SPAN)) begin
      lv_n = LVL_W'(2);
    end else begin
      lv_n = LVL_W'(3);
    end
    lt_n = '0;
    l1_n = '0;
    l2_n = '0;
    l3_n = '0;
    case (lv_n)
      LVL_W'(0): begin
        lt_n = n_clamp[LENT_W-1:0];
      end
      LVL_W'(1): begin
        l1_n = n_clamp[LEN1_W-1:0];
        lt_n = c1[LENT_W-1:0];
      end
      LVL_W'(2): begin
        l2_n = n_clamp[LEN2_W-1:0];
        l1_n = c1[LEN1_W-1:0];
        lt_n = c2[LENT_W-1:0];
      end
      default: begin
        l3_n = n_clamp;
        l2_n = c1;
        l1_n = c2;
        lt_n = c3;
      end
    endcase
    if (fill_used) begin
      init_top = ALL_ONES;
    end else if (lt_n >= LENT_W'(WORD_W)) begin
      init_top = '0;
    end else begin
      init_top = ALL_ONES << lt_n[POS_W-1:0];
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = cur_op;
    lvl_next       = lvl;
    cur_next       = cur;
    path_next      = path;
    top_next       = top_word;
    res_found_next = res_found;
    res_idx_next   = res_idx;
    res_bit_next   = res_bit;
    find_done      = 1'b0;
    find_idx       = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_next        = req.op;
          cur_next       = req.slot_index;
          lvl_next       = level_count;
          path_next      = '0;
          res_found_next = 1'b0;
          res_idx_next   = '0;
          res_bit_next   = 1'b0;
          case (req.op)
            OP_INIT_FREE, OP_INIT_USED: begin
              state_next = S_INIT_PREP;
            end
            OP_SET, OP_CLEAR: begin
              if (!in_range) begin
                state_next = S_DONE;
              end else if (level_count == '0) begin
                state_next = S_TOP;
              end else begin
                state_next = S_RD;
              end
            end
            OP_GET: begin
              if (!in_range) begin
                res_bit_next = 1'b1;
                state_next   = S_DONE;
              end else if (level_count == '0) begin
                state_next = S_TOP;
              end else begin
                state_next = S_RD;
              end
            end
            OP_FIND, OP_FIND_SET: begin
              lvl_next   = LVL_W'(1);
              state_next = S_TOP;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_INIT_PREP: begin
        top_next = init_top;
        if (lv_n != '0) begin
          state_next = S_INIT;
        end else begin
          state_next = reset_pass ? S_IDLE : S_DONE;
        end
      end
      S_INIT: begin
        if (sweep_idx == sweep_last) begin
          state_next = reset_pass ? S_IDLE : S_DONE;
        end
      end
      S_TOP: begin
        case (cur_op)
          OP_SET: begin
            top_next   = wu.set_word;
            state_next = S_DONE;
          end
          OP_CLEAR: begin
            top_next   = wu.clr_word;
            state_next = S_DONE;
          end
          OP_GET: begin
            res_bit_next = wu.bit_val;
            state_next   = S_DONE;
          end
          OP_FIND, OP_FIND_SET: begin
            if (wu.full) begin
              state_next = S_DONE;
            end else begin
              path_next = SLOT_W'(wu.first_zero);
              if (level_count == '0) begin
                find_done = 1'b1;
                find_idx  = SLOT_W'(wu.first_zero);
              end else begin
                state_next = S_RD;
              end
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        case (cur_op)
          OP_SET, OP_CLEAR: begin
            if ((cur_op == OP_SET) ? (wu.full || !wu.set_full) : !wu.full) begin
              state_next = S_DONE;
            end else begin
              cur_next = cur >> POS_W;
              if (lvl == LVL_W'(1)) begin
                state_next = S_TOP;
              end else begin
                lvl_next   = lvl - LVL_W'(1);
                state_next = S_RD;
              end
            end
          end
          OP_GET: begin
            res_bit_next = wu.bit_val;
            state_next   = S_DONE;
          end
          OP_FIND, OP_FIND_SET: begin
            if (wu.full) begin
              state_next = S_DONE;
            end else begin
              path_next = {path[SLOT_W-POS_W-1:0], wu.first_zero};
              if (lvl == level_count) begin
                find_done = 1'b1;
                find_idx  = {path[SLOT_W-POS_W-1:0], wu.first_zero};
              end else begin
                lvl_next   = lvl + LVL_W'(1);
                state_next = S_RD;
              end
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (find_done) begin
      res_found_next = 1'b1;
      res_idx_next   = find_idx;
      if (cur_op == OP_FIND_SET) begin
        op_next    = OP_SET;
        cur_next   = find_idx;
        lvl_next   = level_count;
        state_next = (level_count == '0) ? S_TOP : S_RD;
      end else begin
        state_next = S_DONE;
      end
    end
  end

  always_comb begin
    mem_cmd.wr    = '0;
    mem_cmd.addr  = cur[SLOT_W-1:POS_W];
    mem_cmd.wdata = {NUM_LVL{wu.set_word}};
    if (state == S_INIT) begin
      mem_cmd.addr     = sweep_idx;
      mem_cmd.wr[0]    = (level_count >= LVL_W'(1)) && sweep_hit(CNT_W'(len1), sweep_idx);
      mem_cmd.wr[1]    = (level_count >= LVL_W'(2)) && sweep_hit(CNT_W'(len2), sweep_idx);
      mem_cmd.wr[2]    = (level_count == LVL_W'(3)) && sweep_hit(len3, sweep_idx);
      mem_cmd.wdata[0] = sweep_word(CNT_W'(len1), sweep_idx, fill_used);
      mem_cmd.wdata[1] = sweep_word(CNT_W'(len2), sweep_idx, fill_used);
      mem_cmd.wdata[2] = sweep_word(len3, sweep_idx, fill_used);
    end else if (find_mode) begin
      mem_cmd.addr = path[WIDX_W-1:0];
    end
    if (state == S_WR) begin
      if (cur_op == OP_SET && !wu.full) begin
        mem_cmd.wr[lvl_idx] = 1'b1;
      end
      if (cur_op == OP_CLEAR) begin
        mem_cmd.wr[lvl_idx] = 1'b1;
        mem_cmd.wdata       = {NUM_LVL{wu.clr_word}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT_PREP;
      reset_pass <= 1'b1;
      fill_used  <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (reset_pass && state_next == S_IDLE) begin
        reset_pass <= 1'b0;
      end
      if (state == S_IDLE && req.valid) begin
        fill_used <= (req.op == OP_INIT_USED);
      end
      if (state == S_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_op    <= op_next;
    lvl       <= lvl_next;
    cur       <= cur_next;
    path      <= path_next;
    top_word  <= top_next;
    res_found <= res_found_next;
    res_idx   <= res_idx_next;
    res_bit   <= res_bit_next;
    if (state == S_INIT_PREP) begin
      level_count  <= lv_n;
      active_count <= n_clamp;
      len1         <= l1_n;
      len2         <= l2_n;
      len3         <= l3_n;
      sweep_idx    <= '0;
      sweep_last   <= WIDX_W'(c1 - LEN2_W'(1));
    end else if (state == S_INIT) begin
      sweep_idx <= sweep_idx + WIDX_W'(1);
    end
    if (state == S_DONE && out_free) begin
      rsp.found       <= res_found;
      rsp.found_index <= res_idx;
      rsp.bit_value   <= res_bit;
    end
  end

`ifndef SYNTH
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_DONE)
    else $error("Response raised without a finished operation.");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> mem_cmd.wr == '0)
    else $error("Word memory written while idle.");

  a_walk_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_WR) |-> (lvl != '0 && lvl <= level_count))
    else $error("Tree walk outside the configured levels.");

  a_small_map: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && level_count == '0) |->
      (active_count != '0 && active_count <= CNT_W'(L1_SPAN)))
    else $error("Top-only map holds more slots than the top word.");

  a_busy_clear: assert property (@(posedge clk) disable iff (rst)
    reset_pass |-> !req.ready && !rsp.valid)
    else $error("Request taken during the clearing pass.");
`endif

endmodule

@@ design/hierarchical_free_bit_map.sv @@
// ----------------------------------------------------------------------------
// Hierarchical free bit map
// 32-way tree of used/free bits with find-first-free, APB slot count register.
// ----------------------------------------------------------------------------
// The block keeps one bit per slot (1 means used) in a tree of 32-bit words:
// a top word in flip-flops and up to three lower levels in RAM, where an upper
// bit is set exactly when the word below it is full. Each step of a walk
// through a lower level is a RAM read state followed by an update state
// through the shared word unit; the top word is read and updated in a state
// of its own. A get reads only the word at the lowest level, a set or clear
// walks up from the bottom level and stops at the first word whose full state
// does not change, a find walks down from the top word along first-zero bits
// and a find-and-set adds a set walk. An out-of-range set, clear or get and
// an unused op code go straight to the done state. An init writes all levels
// in parallel, one word index per cycle, or only the top word for a top-only
// map. After reset the block runs an init-free pass over MAX_SLOTS slots
// with ready low; slot_count writes are accepted meanwhile and take effect at
// the next init. A finished result waits in an output register while the
// next item is accepted.
module hierarchical_free_bit_map import hfbm_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  hfbm_req_if.sink          req,
  hfbm_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int WORDS    = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int L1_DEPTH = (WORDS < L1_SPAN) ? WORDS : L1_SPAN;
  localparam int L2_DEPTH = (WORDS < L2_SPAN) ? WORDS : L2_SPAN;
  localparam int L3_DEPTH = (WORDS < L3_SPAN) ? WORDS : L3_SPAN;
  localparam int L1_AW    = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1;
  localparam int L2_AW    = (L2_DEPTH > 1) ? $clog2(L2_DEPTH) : 1;
  localparam int L3_AW    = (L3_DEPTH > 1) ? $clog2(L3_DEPTH) : 1;

  logic [CNT_W-1:0]               slot_count;
  logic                           reg_sel;
  mem_cmd_t                       mem_cmd;
  logic [NUM_LVL-1:0][WORD_W-1:0] mem_rdata;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1:2] == REG_SLOT_COUNT);
  assign prdata  = reg_sel ? APB_DW'(slot_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      slot_count <= pwdata[CNT_W-1:0];
    end
  end

  hfbm_ram #(.WIDTH(WORD_W), .DEPTH(L1_DEPTH)) u_level1 (
    .clk   (clk),
    .we    (mem_cmd.wr[0]),
    .waddr (mem_cmd.addr[L1_AW-1:0]),
    .wdata (mem_cmd.wdata[0]),
    .raddr (mem_cmd.addr[L1_AW-1:0]),
    .rdata (mem_rdata[0])
  );

  hfbm_ram #(.WIDTH(WORD_W), .DEPTH(L2_DEPTH)) u_level2 (
    .clk   (clk),
    .we    (mem_cmd.wr[1]),
    .waddr (mem_cmd.addr[L2_AW-1:0]),
    .wdata (mem_cmd.wdata[1]),
    .raddr (mem_cmd.addr[L2_AW-1:0]),
    .rdata (mem_rdata[1])
  );

  hfbm_ram #(.WIDTH(WORD_W), .DEPTH(L3_DEPTH)) u_level3 (
    .clk   (clk),
    .we    (mem_cmd.wr[2]),
    .waddr (mem_cmd.addr[L3_AW-1:0]),
    .wdata (mem_cmd.wdata[2]),
    .raddr (mem_cmd.addr[L3_AW-1:0]),
    .rdata (mem_rdata[2])
  );

  hfbm_seq #(.MAX_SLOTS(MAX_SLOTS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .slot_count (slot_count),
    .req        (req),
    .rsp        (rsp),
    .mem_cmd    (mem_cmd),
    .mem_rdata  (mem_rdata)
  );

endmodule
